### rtl/windowed_frame_time_stats_top_defines.svh
// Assertion macros shared by the checker file.
`ifndef WINDOWED_FRAME_TIME_STATS_TOP_DEFINES_SVH
`define WINDOWED_FRAME_TIME_STATS_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define WFTS_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication that must hold at every clock edge outside reset.
`define WFTS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/wfts_pkg.sv
package wfts_pkg;

  localparam int TIME_W = 24;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  // GPU status codes.
  localparam logic [STAT_W-1:0] GPU_NA    = 2'd0;
  localparam logic [STAT_W-1:0] GPU_WAIT  = 2'd1;
  localparam logic [STAT_W-1:0] GPU_STATS = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] cpu_time;
    logic [TIME_W-1:0] gpu_time;
    logic              gpu_supported;
    logic              gpu_valid;
  } item_t;

  // Classification made by the front end.
  typedef struct packed {
    logic gpu_push;
    logic gpu_clear;
  } cls_t;

  typedef struct packed {
    item_t item;
    cls_t  cls;
  } fe_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] cpu_now;
    logic [CNT_W-1:0]  cpu_count;
    logic [TIME_W-1:0] cpu_mean;
    logic [TIME_W-1:0] cpu_min;
    logic [TIME_W-1:0] cpu_max;
    logic [STAT_W-1:0] gpu_status;
    logic [TIME_W-1:0] gpu_now;
    logic [CNT_W-1:0]  gpu_count;
    logic [TIME_W-1:0] gpu_mean;
    logic [TIME_W-1:0] gpu_min;
    logic [TIME_W-1:0] gpu_max;
  } result_t;

endpackage

### rtl/wfts_front.sv
module wfts_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  wfts_pkg::item_t   in_item,
  output logic              fe_valid,
  input  logic              fe_pop,
  output wfts_pkg::fe_item_t fe_item
);
  import wfts_pkg::*;

  fe_item_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  fe_item_t   cls_item;

  assign full     = (count == 2'd2);
  assign fe_valid = (count != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = fe_pop && fe_valid;
  assign fe_item  = slots[rd_ptr];

  // Classify the GPU flags of the incoming beat.
  always_comb begin
    cls_item.item          = in_item;
    cls_item.cls.gpu_clear = !in_item.gpu_supported;
    cls_item.cls.gpu_push  = in_item.gpu_supported && in_item.gpu_valid;
  end

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cls_item;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/wfts_back.sv
module wfts_back #(
  parameter int WINDOW = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fe_valid,
  output logic               fe_pop,
  input  wfts_pkg::fe_item_t fe_item,
  output logic               res_valid,
  input  logic               res_pop,
  output wfts_pkg::result_t  res
);
  import wfts_pkg::*;

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = TIME_W + CW;
  localparam int DW = $clog2(SW + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
  localparam logic [CW-1:0] WIN_CNT  = CW'(WINDOW);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PUSH = 5'b00010,
    S_SCAN = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t            state;
  fe_item_t          cur;
  logic [TIME_W-1:0] cpu_ring [WINDOW];
  logic [TIME_W-1:0] gpu_ring [WINDOW];
  logic [IW-1:0]     cpu_head;
  logic [IW-1:0]     gpu_head;
  logic [CW-1:0]     cpu_fill;
  logic [CW-1:0]     gpu_fill;
  logic [TIME_W-1:0] gpu_last;
  logic [CW-1:0]     scan_addr;
  logic              rd_en;
  logic              rd_v;
  logic              rd_g;
  logic [TIME_W-1:0] cpu_rd;
  logic [TIME_W-1:0] gpu_rd;
  logic [SW-1:0]     cpu_q;
  logic [SW-1:0]     gpu_q;
  logic [TIME_W-1:0] cpu_min;
  logic [TIME_W-1:0] cpu_max;
  logic [TIME_W-1:0] gpu_min;
  logic [TIME_W-1:0] gpu_max;
  logic [CW:0]       cpu_rem;
  logic [CW:0]       gpu_rem;
  logic [DW-1:0]     div_cnt;
  logic [CW:0]       cpu_try;
  logic [CW:0]       gpu_try;
  logic              cpu_bit;
  logic              gpu_bit;
  logic              cpu_we;
  logic              gpu_we;
  result_t           res_next;

  assign fe_pop = (state == S_IDLE) && fe_valid;
  assign rd_en  = (state == S_SCAN) && (scan_addr < cpu_fill);
  assign cpu_we = (state == S_PUSH);
  assign gpu_we = (state == S_PUSH) && cur.cls.gpu_push;

  // Window storage: one write port for the push, one read port for the scan.
  always_ff @(posedge clk) begin
    if (cpu_we) begin
      cpu_ring[cpu_head] <= cur.item.cpu_time;
    end
    if (rd_en) begin
      cpu_rd <= cpu_ring[scan_addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (gpu_we) begin
      gpu_ring[gpu_head] <= cur.item.gpu_time;
    end
    if (rd_en) begin
      gpu_rd <= gpu_ring[scan_addr[IW-1:0]];
    end
  end

  // One restoring division step for each window.
  always_comb begin
    cpu_try = {cpu_rem[CW-1:0], cpu_q[SW-1]};
    gpu_try = {gpu_rem[CW-1:0], gpu_q[SW-1]};
    cpu_bit = (cpu_try >= {1'b0, cpu_fill});
    gpu_bit = (gpu_try >= {1'b0, gpu_fill});
  end

  // Result assembly from the finished scan and division.
  always_comb begin
    res_next            = '0;
    res_next.cpu_now    = cur.item.cpu_time;
    res_next.cpu_count  = CNT_W'(cpu_fill);
    res_next.cpu_mean   = cpu_q[TIME_W-1:0];
    res_next.cpu_min    = cpu_min;
    res_next.cpu_max    = cpu_max;
    if (cur.cls.gpu_clear) begin
      res_next.gpu_status = GPU_NA;
    end else if (gpu_fill == '0) begin
      res_next.gpu_status = GPU_WAIT;
    end else begin
      res_next.gpu_status = GPU_STATS;
      res_next.gpu_now    = gpu_last;
      res_next.gpu_count  = CNT_W'(gpu_fill);
      res_next.gpu_mean   = gpu_q[TIME_W-1:0];
      res_next.gpu_min    = gpu_min;
      res_next.gpu_max    = gpu_max;
    end
  end

  // Datapath registers of the capture, push, scan, divide and output steps.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= fe_item;
      end
      S_PUSH: begin
        if (cur.cls.gpu_push) begin
          gpu_last <= cur.item.gpu_time;
        end
        cpu_q   <= '0;
        gpu_q   <= '0;
        cpu_min <= '1;
        cpu_max <= '0;
        gpu_min <= '1;
        gpu_max <= '0;
      end
      S_SCAN: begin
        if (rd_v) begin
          cpu_q <= cpu_q + SW'(cpu_rd);
          if (cpu_rd < cpu_min) begin
            cpu_min <= cpu_rd;
          end
          if (cpu_rd > cpu_max) begin
            cpu_max <= cpu_rd;
          end
          if (rd_g) begin
            gpu_q <= gpu_q + SW'(gpu_rd);
            if (gpu_rd < gpu_min) begin
              gpu_min <= gpu_rd;
            end
            if (gpu_rd > gpu_max) begin
              gpu_max <= gpu_rd;
            end
          end
        end
        cpu_rem <= '0;
        gpu_rem <= '0;
      end
      S_DIV: begin
        cpu_rem <= cpu_bit ? (cpu_try - {1'b0, cpu_fill}) : cpu_try;
        gpu_rem <= gpu_bit ? (gpu_try - {1'b0, gpu_fill}) : gpu_try;
        cpu_q   <= {cpu_q[SW-2:0], cpu_bit};
        gpu_q   <= {gpu_q[SW-2:0], gpu_bit};
      end
      S_OUT: begin
        if (!res_valid) begin
          res <= res_next;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, window pointers and the result slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cpu_head  <= '0;
      gpu_head  <= '0;
      cpu_fill  <= '0;
      gpu_fill  <= '0;
      scan_addr <= '0;
      rd_v      <= 1'b0;
      rd_g      <= 1'b0;
      div_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (fe_valid) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          cpu_head <= (cpu_head == LAST_IDX) ? '0 : cpu_head + IW'(1);
          if (cpu_fill != WIN_CNT) begin
            cpu_fill <= cpu_fill + CW'(1);
          end
          if (cur.cls.gpu_clear) begin
            gpu_head <= '0;
            gpu_fill <= '0;
          end else if (cur.cls.gpu_push) begin
            gpu_head <= (gpu_head == LAST_IDX) ? '0 : gpu_head + IW'(1);
            if (gpu_fill != WIN_CNT) begin
              gpu_fill <= gpu_fill + CW'(1);
            end
          end
          scan_addr <= '0;
          rd_v      <= 1'b0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          rd_v <= rd_en;
          rd_g <= scan_addr < gpu_fill;
          if (rd_en) begin
            scan_addr <= scan_addr + CW'(1);
          end else if (!rd_v) begin
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + DW'(1);
          if (div_cnt == DW'(SW - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/windowed_frame_time_stats_top.sv
// Channel   Handshake            Beat contents
// input     push / full          cpu_time, gpu_time, gpu_supported, gpu_valid
// result    pop / empty          cpu_* and gpu_* statistics of one frame
//
// The scan reads one entry of each window per cycle, then two restoring dividers, one per
// window, take one quotient bit per cycle for both means.
// rst is synchronous and clears the windows' counts; ring contents need no clear.
// A two-beat input queue accepts beats while the engine or result slot stalls, until full.
module windowed_frame_time_stats_top #(
  parameter int WINDOW = 100
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [wfts_pkg::TIME_W-1:0]   cpu_time,
  input  logic [wfts_pkg::TIME_W-1:0]   gpu_time,
  input  logic                          gpu_supported,
  input  logic                          gpu_valid,
  output logic                          empty,
  input  logic                          pop,
  output logic [wfts_pkg::TIME_W-1:0]   cpu_now,
  output logic [wfts_pkg::CNT_W-1:0]    cpu_count,
  output logic [wfts_pkg::TIME_W-1:0]   cpu_mean,
  output logic [wfts_pkg::TIME_W-1:0]   cpu_min,
  output logic [wfts_pkg::TIME_W-1:0]   cpu_max,
  output logic [wfts_pkg::STAT_W-1:0]   gpu_status,
  output logic [wfts_pkg::TIME_W-1:0]   gpu_now,
  output logic [wfts_pkg::CNT_W-1:0]    gpu_count,
  output logic [wfts_pkg::TIME_W-1:0]   gpu_mean,
  output logic [wfts_pkg::TIME_W-1:0]   gpu_min,
  output logic [wfts_pkg::TIME_W-1:0]   gpu_max
);
  import wfts_pkg::*;

  item_t    in_item;
  fe_item_t fe_item;
  logic     fe_valid;
  logic     fe_pop;
  logic     res_valid;
  result_t  res;

  // Gather the input beat.
  always_comb begin
    in_item.cpu_time      = cpu_time;
    in_item.gpu_time      = gpu_time;
    in_item.gpu_supported = gpu_supported;
    in_item.gpu_valid     = gpu_valid;
  end

  wfts_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .fe_valid (fe_valid),
    .fe_pop   (fe_pop),
    .fe_item  (fe_item)
  );

  wfts_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .fe_valid  (fe_valid),
    .fe_pop    (fe_pop),
    .fe_item   (fe_item),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res       (res)
  );

  // Result beat onto the ports.
  assign empty      = !res_valid;
  assign cpu_now    = res.cpu_now;
  assign cpu_count  = res.cpu_count;
  assign cpu_mean   = res.cpu_mean;
  assign cpu_min    = res.cpu_min;
  assign cpu_max    = res.cpu_max;
  assign gpu_status = res.gpu_status;
  assign gpu_now    = res.gpu_now;
  assign gpu_count  = res.gpu_count;
  assign gpu_mean   = res.gpu_mean;
  assign gpu_min    = res.gpu_min;
  assign gpu_max    = res.gpu_max;

endmodule

### rtl/wfts_checker.sv
`include "windowed_frame_time_stats_top_defines.svh"

module wfts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        empty,
  input logic [wfts_pkg::CNT_W-1:0]  cpu_count,
  input logic [wfts_pkg::TIME_W-1:0] cpu_mean,
  input logic [wfts_pkg::TIME_W-1:0] cpu_min,
  input logic [wfts_pkg::TIME_W-1:0] cpu_max,
  input logic [wfts_pkg::STAT_W-1:0] gpu_status,
  input logic [wfts_pkg::CNT_W-1:0]  gpu_count
);
  import wfts_pkg::*;

  // The CPU window always holds the current frame.
  `WFTS_IMPLIES(a_cpu_count, !empty, cpu_count != '0, "CPU count is zero")
  // The mean lies between the extremes of its window.
  `WFTS_IMPLIES(a_cpu_order, !empty, (cpu_min <= cpu_mean) && (cpu_mean <= cpu_max), "CPU order")
  // Status codes and the GPU count agree.
  `WFTS_IMPLIES(a_gpu_code, !empty, gpu_status <= GPU_STATS, "GPU status code unused")
  `WFTS_IMPLIES(a_gpu_count, !empty && (gpu_status != GPU_STATS), gpu_count == '0, "GPU count set")

endmodule

bind windowed_frame_time_stats_top wfts_checker u_wfts_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .cpu_count  (cpu_count),
  .cpu_mean   (cpu_mean),
  .cpu_min    (cpu_min),
  .cpu_max    (cpu_max),
  .gpu_status (gpu_status),
  .gpu_count  (gpu_count)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wfts_pkg::*;

  localparam int WIN = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [TIME_W-1:0] cpu_time = '0;
  logic [TIME_W-1:0] gpu_time = '0;
  logic gpu_supported = 1'b0;
  logic gpu_valid = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [TIME_W-1:0] cpu_now, cpu_mean, cpu_min, cpu_max;
  logic [TIME_W-1:0] gpu_now, gpu_mean, gpu_min, gpu_max;
  logic [CNT_W-1:0] cpu_count, gpu_count;
  logic [STAT_W-1:0] gpu_status;

  windowed_frame_time_stats_top #(.WINDOW(WIN)) DUT (.*);

  always #5 clk = ~clk;

  // Frames waiting to be sent, and statistics waiting to come back.
  item_t frame_q[$];
  result_t stats_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit failed = 1'b0;

  // Predictor state: both sliding windows.
  logic [TIME_W-1:0] cpu_win[WIN];
  logic [TIME_W-1:0] gpu_win[WIN];
  int cpu_n = 0, cpu_wp = 0, gpu_n = 0, gpu_wp = 0;

  // Summarize the newest n entries of a window ending just before wp.
  function automatic void scan_window(input logic [TIME_W-1:0] w[WIN], input int n,
                                      input int wp, output logic [TIME_W-1:0] mean,
                                      output logic [TIME_W-1:0] lo,
                                      output logic [TIME_W-1:0] hi);
    longint sum;
    int idx;
    sum = 0;
    lo = '1;
    hi = '0;
    for (int i = 0; i < n; i++) begin
      idx = (wp - 1 - i + 2 * WIN) % WIN;
      sum += w[idx];
      if (w[idx] < lo) lo = w[idx];
      if (w[idx] > hi) hi = w[idx];
    end
    mean = TIME_W'(sum / n);
  endfunction

  // Update the windows with one frame and return the statistics it produces.
  function automatic result_t predict_stats(input item_t f);
    result_t r;
    r = '0;
    cpu_win[cpu_wp] = f.cpu_time;
    cpu_wp = (cpu_wp + 1) % WIN;
    if (cpu_n < WIN) cpu_n++;
    r.cpu_now = f.cpu_time;
    r.cpu_count = CNT_W'(cpu_n);
    scan_window(cpu_win, cpu_n, cpu_wp, r.cpu_mean, r.cpu_min, r.cpu_max);
    if (!f.gpu_supported) begin
      gpu_n = 0;
      gpu_wp = 0;
      r.gpu_status = GPU_NA;
    end else begin
      if (f.gpu_valid) begin
        gpu_win[gpu_wp] = f.gpu_time;
        gpu_wp = (gpu_wp + 1) % WIN;
        if (gpu_n < WIN) gpu_n++;
      end
      if (gpu_n == 0) begin
        r.gpu_status = GPU_WAIT;
      end else begin
        r.gpu_status = GPU_STATS;
        r.gpu_now = gpu_win[(gpu_wp + WIN - 1) % WIN];
        r.gpu_count = CNT_W'(gpu_n);
        scan_window(gpu_win, gpu_n, gpu_wp, r.gpu_mean, r.gpu_min, r.gpu_max);
      end
    end
    return r;
  endfunction

  // Driver: one beat per accepted push, with random idle cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        stats_q.insert(stats_q.size(), predict_stats(frame_q[0]));
        frame_q.delete(0);
      end
      if (frame_q.size() > 0 && !(push && !full && frame_q.size() == 0)
          && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        cpu_time <= frame_q[0].cpu_time;
        gpu_time <= frame_q[0].gpu_time;
        gpu_supported <= frame_q[0].gpu_supported;
        gpu_valid <= frame_q[0].gpu_valid;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: compare each popped beat with the oldest prediction.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst) begin
      if (pop && !empty) begin
        got = '{cpu_now, cpu_count, cpu_mean, cpu_min, cpu_max, gpu_status,
                gpu_now, gpu_count, gpu_mean, gpu_min, gpu_max};
        if (stats_q.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          failed = 1'b1;
        end else begin
          want = stats_q[0];
          stats_q.delete(0);
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            failed = 1'b1;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Queue one frame.
  task automatic add_frame(input logic [TIME_W-1:0] c, input logic [TIME_W-1:0] g,
                           input logic s, input logic v);
    item_t f;
    f.cpu_time = c;
    f.gpu_time = g;
    f.gpu_supported = s;
    f.gpu_valid = v;
    frame_q.insert(frame_q.size(), f);
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(3))
      0: return TIME_W'($urandom);
      1: return TIME_W'($urandom_range(2000, 8000));
      2: return {TIME_W{1'b1}} - TIME_W'($urandom_range(15));
      default: return TIME_W'($urandom_range(15));
    endcase
  endfunction

  task automatic wait_drain();
    while (frame_q.size() > 0 || push || stats_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, waiting, not available and reappearing GPU.
    add_frame('0, '0, 1'b0, 1'b0);
    add_frame('1, '1, 1'b1, 1'b0);
    add_frame('1, '1, 1'b1, 1'b1);
    add_frame('0, '0, 1'b1, 1'b1);
    add_frame(24'h123456, 24'hABCDEF, 1'b1, 1'b0);
    add_frame('1, '1, 1'b0, 1'b1);
    add_frame(24'd1, 24'd2, 1'b1, 1'b0);
    add_frame(24'd3, 24'd5, 1'b1, 1'b1);
    for (int i = 0; i < 15; i++) add_frame('1, '1, 1'b1, 1'b1);
    wait_drain();

    // Random phases; long valid runs fill and wrap the windows.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 86 : 15) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 86 : 15) : 0;
      for (int i = 0; i < 470; i++) begin
        r = $urandom_range(99);
        add_frame(rand_time(), rand_time(), r >= 3, r < 85 || r >= 97);
      end
      wait_drain();
    end

    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
